// ===== rtl/core/fri_pkg.sv =====
// Shared types and constants for the FASTA record indexer.
// Holds byte codes, the result record type and the whitespace test.
// No dependencies.
`default_nettype none

package fri_pkg;

  localparam int unsigned HEADER_LINE_BITS = 32;
  localparam int unsigned LINE_TOTAL_BITS  = 32;
  localparam int unsigned BASE_TOTAL_BITS  = 40;
  localparam int unsigned OUT_DATA_BITS    = 104;
  localparam int unsigned IN_DATA_BITS     = 8;

  localparam logic [7:0] CHAR_HEADER  = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_COMMENT = 8'h3B;  // ';'
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0A;

  // Input item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Result kinds
  localparam logic RES_SUMMARY   = 1'b0;
  localparam logic RES_MALFORMED = 1'b1;

  typedef struct packed {
    logic [BASE_TOTAL_BITS-1:0]  base_total;
    logic [LINE_TOTAL_BITS-1:0]  line_total;
    logic [HEADER_LINE_BITS-1:0] header_line;
    logic                        result_kind;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_CR) || (b == CHAR_TAB) || (b == CHAR_LF);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fri_parse.sv =====
// Parser state and per-byte update for the FASTA record indexer.
// Depends on fri_pkg for byte codes and the result record type.
`default_nettype none

module fri_parse
  import fri_pkg::*;
#(
  parameter int unsigned LINE_COUNT_BITS = 32,
  parameter int unsigned BASE_COUNT_BITS = 40
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       kind,
  input  wire logic [7:0] text_byte,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_HEAD,
    PH_BODY,
    PH_STOP
  } phase_t;

  localparam logic [LINE_COUNT_BITS-1:0] LINE_ONE = LINE_COUNT_BITS'(1);
  localparam logic [BASE_COUNT_BITS-1:0] BASE_ONE = BASE_COUNT_BITS'(1);

  phase_t                     phase, phase_next;
  logic                       at_line_start, at_line_start_next;
  logic                       comment_line, comment_line_next;
  logic [LINE_COUNT_BITS-1:0] line_number, line_number_next;
  logic [LINE_COUNT_BITS-1:0] record_first_line, record_first_line_next;
  logic [LINE_COUNT_BITS-1:0] record_line_count, record_line_count_next;
  logic [BASE_COUNT_BITS-1:0] record_base_count, record_base_count_next;

  logic [LINE_COUNT_BITS-1:0] line_count_inc, line_number_inc;
  logic [BASE_COUNT_BITS-1:0] base_count_inc;
  logic                       is_space;

  assign line_count_inc  = (&record_line_count) ? record_line_count
                                                : record_line_count + LINE_ONE;
  assign line_number_inc = (&line_number) ? line_number : line_number + LINE_ONE;
  assign base_count_inc  = (&record_base_count) ? record_base_count
                                                : record_base_count + BASE_ONE;
  assign is_space        = is_ws(text_byte);

  always_comb begin
    phase_next             = phase;
    at_line_start_next     = at_line_start;
    comment_line_next      = comment_line;
    line_number_next       = line_number;
    record_first_line_next = record_first_line;
    record_line_count_next = record_line_count;
    record_base_count_next = record_base_count;
    res_valid              = 1'b0;
    res.result_kind        = RES_SUMMARY;
    res.header_line        = HEADER_LINE_BITS'(record_first_line);
    res.line_total         = LINE_TOTAL_BITS'(record_line_count);
    res.base_total         = BASE_TOTAL_BITS'(record_base_count);

    if (accept && phase != PH_STOP) begin
      if (kind == KIND_END) begin
        if (phase == PH_HEAD || phase == PH_BODY) begin
          res_valid = 1'b1;
          if (phase == PH_BODY && !at_line_start) begin
            res.line_total = LINE_TOTAL_BITS'(line_count_inc);
          end
        end
        phase_next = PH_STOP;
      end else if (text_byte == CHAR_LF) begin
        if (phase == PH_BODY) begin
          record_line_count_next = line_count_inc;
        end else if (phase == PH_HEAD) begin
          phase_next = PH_BODY;
        end
        line_number_next   = line_number_inc;
        at_line_start_next = 1'b1;
        comment_line_next  = 1'b0;
      end else if (phase == PH_LEAD) begin
        priority if (at_line_start && text_byte == CHAR_HEADER) begin
          at_line_start_next     = 1'b0;
          record_first_line_next = line_number;
          record_line_count_next = '0;
          record_base_count_next = '0;
          phase_next             = PH_HEAD;
        end else if (at_line_start && text_byte == CHAR_COMMENT) begin
          at_line_start_next = 1'b0;
          comment_line_next  = 1'b1;
        end else begin
          at_line_start_next = 1'b0;
          if (!comment_line && !is_space) begin
            res_valid       = 1'b1;
            res.result_kind = RES_MALFORMED;
            res.header_line = '0;
            res.line_total  = '0;
            res.base_total  = '0;
            phase_next      = PH_STOP;
          end
        end
      end else if (phase == PH_BODY) begin
        priority if (at_line_start && text_byte == CHAR_HEADER) begin
          at_line_start_next     = 1'b0;
          res_valid              = 1'b1;
          record_first_line_next = line_number;
          record_line_count_next = '0;
          record_base_count_next = '0;
          phase_next             = PH_HEAD;
        end else if (at_line_start && text_byte == CHAR_COMMENT) begin
          at_line_start_next = 1'b0;
          comment_line_next  = 1'b1;
        end else begin
          at_line_start_next = 1'b0;
          if (!comment_line && !is_space) begin
            record_base_count_next = base_count_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEAD;
      at_line_start     <= 1'b1;
      comment_line      <= 1'b0;
      line_number       <= '0;
      record_first_line <= '0;
      record_line_count <= '0;
      record_base_count <= '0;
    end else begin
      phase             <= phase_next;
      at_line_start     <= at_line_start_next;
      comment_line      <= comment_line_next;
      line_number       <= line_number_next;
      record_first_line <= record_first_line_next;
      record_line_count <= record_line_count_next;
      record_base_count <= record_base_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fri_out.sv =====
// Output register with skid stage for FASTA indexer results.
// Depends on fri_pkg for the result record type and field widths.
`default_nettype none

module fri_out
  import fri_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire result_t                  push_data,
  output logic                          push_ready,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0]      m_tdata,
  output logic                          m_tuser
);

  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    draining;

  // The output slot frees up when empty or when its request is taken.
  assign draining   = !out_valid || m_tready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!draining) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= push;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!draining) begin
      if (push) begin
        skid_data <= push_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
      if (push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      out_data <= push_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_data.result_kind;
  assign m_tdata  = {out_data.base_total, out_data.line_total, out_data.header_line};

endmodule

`default_nettype wire

// ===== rtl/core/fasta_record_indexer_top.sv =====
// FASTA record indexer: one byte request per cycle, at most one result each.
// A result is registered into the output register, or into the skid stage while that is held.
// Throughput: one request per cycle; the skid stage behind the output register
//   holds one extra result, so the slave side stalls only when both are full.
// Reset (rst, synchronous, active high) returns to the leading section and empties
//   the output stages. Depends on fri_pkg, fri_parse and fri_out.
`default_nettype none

module fasta_record_indexer_top
  import fri_pkg::*;
#(
  parameter int unsigned LINE_COUNT_BITS = 32,
  parameter int unsigned BASE_COUNT_BITS = 40
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Slave side: one file byte or the end marker per request
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,   // [7:0] text_byte
  input  wire logic                     s_tuser,   // [0] kind: 0 byte, 1 end of input
  // Master side: record summaries and the malformed-text error
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0]      m_tdata,   // [31:0] header_line, [63:32] line_total,
                                                   // [103:64] base_total
  output logic                          m_tuser    // [0] result_kind: 0 summary, 1 malformed
);

  logic    accept;
  logic    res_valid;
  result_t res;

  // A request is taken whenever the skid stage is free; the parser state
  // advances on the same edge and its result drops into the output stages.
  assign accept = s_tvalid && s_tready;

  fri_parse #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS),
    .BASE_COUNT_BITS(BASE_COUNT_BITS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (s_tuser),
    .text_byte (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  fri_out u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire
